[design/lphm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lphm_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = 8;
  localparam int CUR_W    = 9;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;

  localparam logic [CUR_W-1:0] CURSOR_END = 9'(CAPACITY + 1);

  // Command codes.
  localparam logic [2:0] CMD_SET_OR_ADD = 3'd0;
  localparam logic [2:0] CMD_GET_OR_ADD = 3'd1;
  localparam logic [2:0] CMD_LOOKUP     = 3'd2;
  localparam logic [2:0] CMD_LOOKUP_DEL = 3'd3;
  localparam logic [2:0] CMD_ITER_NEXT  = 3'd4;

  // Result status codes.
  localparam logic [1:0] STS_HIT   = 2'd0;
  localparam logic [1:0] STS_ADDED = 2'd1;
  localparam logic [1:0] STS_MISS  = 2'd2;
  localparam logic [1:0] STS_FULL  = 2'd3;

  // Result selects from controller to datapath.
  localparam logic [2:0] RES_HIT_MEM  = 3'd0;
  localparam logic [2:0] RES_HIT_NEW  = 3'd1;
  localparam logic [2:0] RES_ADDED    = 3'd2;
  localparam logic [2:0] RES_MISS     = 3'd3;
  localparam logic [2:0] RES_FULL     = 3'd4;
  localparam logic [2:0] RES_ITER_HIT = 3'd5;
  localparam logic [2:0] RES_ITER_END = 3'd6;

  typedef struct packed {
    logic       load;       // latch input transaction, start probe/iteration
    logic       rd;         // issue a table read
    logic       rd_iter;    // read address from iteration position
    logic       probe_adv;  // step the probe to the next slot
    logic       iter_adv;   // follow the stored link of a deleted slot
    logic       wr_entry;   // write key, value and live mark
    logic       use_del;    // entry write targets the remembered deleted slot
    logic       wr_value;   // overwrite value at probe slot
    logic       wr_delete;  // mark probe slot deleted
    logic       link_tail;  // append probe slot to insertion chain
    logic       link_self;  // terminate the link of the probe slot
    logic       res_en;
    logic [2:0] res_sel;
    logic       out_load;
  } lphm_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       hit;
    logic       empty;
    logic       live;
    logic       last;
    logic       have_del;
    logic       full;
    logic       pos_bad;
  } lphm_sts_t;

endpackage
`default_nettype wire

[design/lphm_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module lphm_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [2:0]                    command,
  input  wire logic [lphm_pkg::KEY_W-1:0]    lookup_key,
  input  wire logic [lphm_pkg::VAL_W-1:0]    new_value,
  input  wire logic [lphm_pkg::CUR_W-1:0]    cursor,
  input  wire logic                          cfg_we,
  input  wire logic [7:0]                    cfg_data,
  input  wire lphm_pkg::lphm_cmd_t           cmd,
  output lphm_pkg::lphm_sts_t                sts,
  output logic [1:0]                         status,
  output logic [lphm_pkg::KEY_W-1:0]         found_key,
  output logic [lphm_pkg::VAL_W-1:0]         found_value,
  output logic [lphm_pkg::CUR_W-1:0]         next_cursor
);

  localparam int SW = lphm_pkg::SLOT_W;
  localparam int CW = lphm_pkg::CUR_W;

  // Table storage. Only the valid flags are reset; the rest is read only
  // after the slot has been written.
  logic [lphm_pkg::KEY_W-1:0] key_mem  [lphm_pkg::CAPACITY];
  logic [lphm_pkg::VAL_W-1:0] val_mem  [lphm_pkg::CAPACITY];
  logic [CW-1:0]              link_mem [lphm_pkg::CAPACITY];
  logic                       del_mem  [lphm_pkg::CAPACITY];
  logic [lphm_pkg::CAPACITY-1:0] slot_valid;

  logic [7:0]                 limit;
  logic [CW-1:0]              count;
  logic [CW-1:0]              head;
  logic [CW-1:0]              tail;

  logic [2:0]                 op;
  logic [lphm_pkg::KEY_W-1:0] key_r;
  logic [lphm_pkg::VAL_W-1:0] val_r;
  logic [SW-1:0]              idx;
  logic [SW-1:0]              step;
  logic [SW-1:0]              del_slot;
  logic                       have_del;
  logic [CW-1:0]              pos;

  logic                       rd_valid;
  logic                       rd_del;
  logic [lphm_pkg::KEY_W-1:0] rd_key;
  logic [lphm_pkg::VAL_W-1:0] rd_val;
  logic [CW-1:0]              rd_link;

  logic [1:0]                 res_status;
  logic [lphm_pkg::KEY_W-1:0] res_key;
  logic [lphm_pkg::VAL_W-1:0] res_val;
  logic [CW-1:0]              res_cursor;

  logic [SW-1:0]              rd_addr;
  logic [SW-1:0]              wr_addr;
  logic [CW-1:0]              pos_m1;
  logic [CW-1:0]              tail_m1;
  logic [CW-1:0]              idx_p1;

  assign pos_m1  = pos - 9'd1;
  assign tail_m1 = tail - 9'd1;
  assign idx_p1  = {1'b0, idx} + 9'd1;
  assign rd_addr = cmd.rd_iter ? pos_m1[SW-1:0] : idx;
  assign wr_addr = cmd.use_del ? del_slot : idx;

  always_comb begin
    sts.op       = op;
    sts.hit      = rd_valid && !rd_del && (rd_key == key_r);
    sts.empty    = !rd_valid;
    sts.live     = rd_valid && !rd_del;
    sts.last     = &step;
    sts.have_del = have_del;
    sts.full     = count >= {1'b0, limit};
    sts.pos_bad  = (pos == '0) || (pos > 9'(lphm_pkg::CAPACITY));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit      <= 8'd128;
      count      <= '0;
      head       <= '0;
      tail       <= '0;
      slot_valid <= '0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (cmd.link_tail) begin
        if (tail == '0) begin
          head <= idx_p1;
        end
        tail            <= idx_p1;
        count           <= count + 9'd1;
        slot_valid[idx] <= 1'b1;
      end
    end
  end

  // Table write ports.
  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      key_mem[wr_addr] <= key_r;
    end
    if (cmd.wr_entry || cmd.wr_value) begin
      val_mem[wr_addr] <= val_r;
    end
    if (cmd.wr_entry || cmd.wr_delete) begin
      del_mem[wr_addr] <= cmd.wr_delete;
    end
    if (cmd.link_tail && tail != '0) begin
      link_mem[tail_m1[SW-1:0]] <= idx_p1;
    end else if (cmd.link_self) begin
      link_mem[idx] <= '0;
    end
  end

  // Registered table read.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_valid <= slot_valid[rd_addr];
      rd_del   <= del_mem[rd_addr];
      rd_key   <= key_mem[rd_addr];
      rd_val   <= val_mem[rd_addr];
      rd_link  <= link_mem[rd_addr];
    end
  end

  // Transaction and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= command;
      key_r    <= lookup_key;
      val_r    <= new_value;
      idx      <= lookup_key[SW-1:0];
      step     <= '0;
      have_del <= 1'b0;
      pos      <= (cursor == '0) ? head : cursor;
    end else if (cmd.probe_adv) begin
      if (rd_valid && rd_del) begin
        del_slot <= idx;
        have_del <= 1'b1;
      end
      idx  <= idx + 8'd1;
      step <= step + 8'd1;
    end else if (cmd.iter_adv) begin
      pos  <= rd_link;
      step <= step + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      unique case (cmd.res_sel)
        lphm_pkg::RES_HIT_MEM: begin
          res_status <= lphm_pkg::STS_HIT;
          res_key    <= '0;
          res_val    <= rd_val;
          res_cursor <= '0;
        end
        lphm_pkg::RES_HIT_NEW: begin
          res_status <= lphm_pkg::STS_HIT;
          res_key    <= '0;
          res_val    <= val_r;
          res_cursor <= '0;
        end
        lphm_pkg::RES_ADDED: begin
          res_status <= lphm_pkg::STS_ADDED;
          res_key    <= '0;
          res_val    <= val_r;
          res_cursor <= '0;
        end
        lphm_pkg::RES_FULL: begin
          res_status <= lphm_pkg::STS_FULL;
          res_key    <= '0;
          res_val    <= '0;
          res_cursor <= '0;
        end
        lphm_pkg::RES_ITER_HIT: begin
          res_status <= lphm_pkg::STS_HIT;
          res_key    <= rd_key;
          res_val    <= rd_val;
          res_cursor <= (rd_link == '0) ? lphm_pkg::CURSOR_END : rd_link;
        end
        lphm_pkg::RES_ITER_END: begin
          res_status <= lphm_pkg::STS_MISS;
          res_key    <= '0;
          res_val    <= '0;
          res_cursor <= lphm_pkg::CURSOR_END;
        end
        default: begin
          res_status <= lphm_pkg::STS_MISS;
          res_key    <= '0;
          res_val    <= '0;
          res_cursor <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= res_status;
      found_key   <= res_key;
      found_value <= res_val;
      next_cursor <= res_cursor;
    end
  end

endmodule
`default_nettype wire

[design/lphm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module lphm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          command,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire lphm_pkg::lphm_sts_t sts,
  output lphm_pkg::lphm_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_P_RD  = 3'd1;
  localparam logic [2:0] S_P_CK  = 3'd2;
  localparam logic [2:0] S_P_END = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_I_POS = 3'd5;
  localparam logic [2:0] S_I_CK  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       is_insert;

  assign in_stall  = (state != S_IDLE);
  assign is_insert = (sts.op == lphm_pkg::CMD_SET_OR_ADD) ||
                     (sts.op == lphm_pkg::CMD_GET_OR_ADD);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (command == lphm_pkg::CMD_ITER_NEXT) begin
            state_next = S_I_POS;
          end else if (command < lphm_pkg::CMD_ITER_NEXT) begin
            state_next = S_P_RD;
          end else begin
            cmd.res_en  = 1'b1;
            cmd.res_sel = lphm_pkg::RES_MISS;
            state_next  = S_DONE;
          end
        end
      end
      S_P_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_P_CK;
      end
      S_P_CK: begin
        cmd.res_en = 1'b1;
        state_next = S_DONE;
        if (sts.hit) begin
          case (sts.op)
            lphm_pkg::CMD_SET_OR_ADD: begin
              cmd.wr_value = 1'b1;
              cmd.res_sel  = lphm_pkg::RES_HIT_NEW;
            end
            lphm_pkg::CMD_LOOKUP_DEL: begin
              cmd.wr_delete = 1'b1;
              cmd.res_sel   = lphm_pkg::RES_HIT_MEM;
            end
            default: begin
              cmd.res_sel = lphm_pkg::RES_HIT_MEM;
            end
          endcase
        end else if (sts.empty) begin
          if (!is_insert) begin
            cmd.res_sel = lphm_pkg::RES_MISS;
          end else if (sts.have_del) begin
            cmd.wr_entry = 1'b1;
            cmd.use_del  = 1'b1;
            cmd.res_sel  = lphm_pkg::RES_ADDED;
          end else if (sts.full) begin
            cmd.res_sel = lphm_pkg::RES_FULL;
          end else begin
            cmd.wr_entry  = 1'b1;
            cmd.link_tail = 1'b1;
            cmd.res_sel   = lphm_pkg::RES_ADDED;
            state_next    = S_LINK;
          end
        end else begin
          cmd.res_en    = 1'b0;
          cmd.probe_adv = 1'b1;
          state_next    = sts.last ? S_P_END : S_P_RD;
        end
      end
      S_P_END: begin
        cmd.res_en = 1'b1;
        state_next = S_DONE;
        if (!is_insert) begin
          cmd.res_sel = lphm_pkg::RES_MISS;
        end else if (sts.have_del) begin
          cmd.wr_entry = 1'b1;
          cmd.use_del  = 1'b1;
          cmd.res_sel  = lphm_pkg::RES_ADDED;
        end else begin
          cmd.res_sel = lphm_pkg::RES_FULL;
        end
      end
      S_LINK: begin
        cmd.link_self = 1'b1;
        state_next    = S_DONE;
      end
      S_I_POS: begin
        if (sts.pos_bad) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = lphm_pkg::RES_ITER_END;
          state_next  = S_DONE;
        end else begin
          cmd.rd      = 1'b1;
          cmd.rd_iter = 1'b1;
          state_next  = S_I_CK;
        end
      end
      S_I_CK: begin
        if (sts.empty) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = lphm_pkg::RES_ITER_END;
          state_next  = S_DONE;
        end else if (sts.live) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = lphm_pkg::RES_ITER_HIT;
          state_next  = S_DONE;
        end else if (sts.last) begin
          cmd.res_en  = 1'b1;
          cmd.res_sel = lphm_pkg::RES_ITER_END;
          state_next  = S_DONE;
        end else begin
          cmd.iter_adv = 1'b1;
          state_next   = S_I_POS;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[design/linear_probe_hash_map.sv]
`timescale 1ns / 1ps
`default_nettype none
// Hash map of 64-bit keys to 64-bit values in a 256-slot table with linear
// probing from the home slot given by the key's low eight bits. A transaction
// is accepted only while the block is idle, one at a time. Each probe step
// is a registered table read followed by a compare, and a lookup or insert
// holds the block from its acceptance through every slot visited until its
// result is loaded into the output register. An append to the insertion
// chain adds a second link write, and a probe that visits all 256 slots
// without meeting an empty one adds a separate step to decide. An iterate
// call reads slots along the chain, one more read for each deleted slot
// skipped, and ends without a read when the cursor points nowhere; an unused
// command code goes straight to the result. A stalled output holds the block
// while the result register is still full. The table has a single read port.
// The output register lets a new transaction enter while the previous result
// still waits downstream. Inserts that need a fresh slot are refused with the
// full status once the populated count (live plus deleted slots) reaches the
// limit register, written through the cfg port (reset value 128). Deleted
// slots keep their place in insertion order and are reused by later inserts
// that pass them. Per-slot valid flags are cleared by reset, so no clearing
// pass is needed.
module linear_probe_hash_map (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [2:0]                 command,
  input  wire logic [lphm_pkg::KEY_W-1:0] lookup_key,
  input  wire logic [lphm_pkg::VAL_W-1:0] new_value,
  input  wire logic [lphm_pkg::CUR_W-1:0] cursor,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      status,
  output logic [lphm_pkg::KEY_W-1:0]      found_key,
  output logic [lphm_pkg::VAL_W-1:0]      found_value,
  output logic [lphm_pkg::CUR_W-1:0]      next_cursor,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [7:0]                 cfg_data
);

  lphm_pkg::lphm_cmd_t cmd;
  lphm_pkg::lphm_sts_t sts;

  // The limit register can take a write in any cycle.
  assign cfg_ready = 1'b1;

  lphm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lphm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .command     (command),
    .lookup_key  (lookup_key),
    .new_value   (new_value),
    .cursor      (cursor),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .status      (status),
    .found_key   (found_key),
    .found_value (found_value),
    .next_cursor (next_cursor)
  );

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import lphm_pkg::*;

  // Slot states kept by the predictor.
  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_LIVE    = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  // Unused command codes, which the block must answer as a miss.
  localparam logic [2:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  localparam logic [63:0] ALL_ONES = ~64'd0;

  typedef struct packed {
    logic [1:0]       sts;
    logic [KEY_W-1:0] fkey;
    logic [VAL_W-1:0] fval;
    logic [CUR_W-1:0] ncur;
  } map_result_t;

  // One row of the directed part. When typed is set, the result is written
  // into the row by hand; otherwise the predictor supplies it.
  typedef struct {
    logic [2:0]       cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic [CUR_W-1:0] cur;
    bit               typed;
    map_result_t      res;
  } directed_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [2:0]       command;
  logic [KEY_W-1:0] lookup_key;
  logic [VAL_W-1:0] new_value;
  logic [CUR_W-1:0] cursor;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       status;
  logic [KEY_W-1:0] found_key;
  logic [VAL_W-1:0] found_value;
  logic [CUR_W-1:0] next_cursor;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [7:0]       cfg_data;

  linear_probe_hash_map DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .lookup_key(lookup_key), .new_value(new_value), .cursor(cursor),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .found_key(found_key), .found_value(found_value),
    .next_cursor(next_cursor),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow copy of the table, the insertion chain and the limit register.
  logic [1:0]       shadow_state [CAPACITY];
  logic [KEY_W-1:0] shadow_key   [CAPACITY];
  logic [VAL_W-1:0] shadow_value [CAPACITY];
  logic [CUR_W-1:0] shadow_link  [CAPACITY];
  logic [CUR_W-1:0] order_head;
  logic [CUR_W-1:0] order_tail;
  int unsigned      populated;
  logic [7:0]       fill_limit;

  map_result_t pending_results[$];
  logic [KEY_W-1:0] key_pool[48];
  logic [CUR_W-1:0] walk_cursor;
  int  fail_count;
  int  items_sent;
  int  results_seen;
  int  full_seen;
  int  reuse_seen;
  int  iter_hits;
  bit  quiet;        // no idling on either side once set
  bit  hold_done;

  // Walks the probe sequence for a key. Returns 1 on a hit, 0 on a miss with a
  // usable slot, -1 when no slot can take the key.
  function automatic int probe_table(input logic [KEY_W-1:0] key,
                                     output int slot, output bit reuse);
    int idx;
    int del_slot;
    bit have_del;
    slot = 0;
    reuse = 0;
    have_del = 0;
    del_slot = 0;
    idx = int'(key[SLOT_W-1:0]);
    for (int n = 0; n < CAPACITY; n++) begin
      if (shadow_state[idx] == SLOT_EMPTY) begin
        if (have_del) begin
          slot = del_slot;
          reuse = 1;
        end else begin
          slot = idx;
        end
        return 0;
      end
      if (shadow_state[idx] == SLOT_LIVE) begin
        if (shadow_key[idx] == key) begin
          slot = idx;
          return 1;
        end
      end else begin
        have_del = 1;
        del_slot = idx;
      end
      idx = (idx + 1) % CAPACITY;
    end
    if (have_del) begin
      slot = del_slot;
      reuse = 1;
      return 0;
    end
    return -1;
  endfunction

  // Applies one transaction to the shadow table and returns its result.
  function automatic map_result_t apply_map_op(input logic [2:0] cmd,
      input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val,
      input logic [CUR_W-1:0] cur);
    map_result_t r;
    int slot;
    bit reuse;
    int hit;
    int pos;
    r = '{sts: STS_MISS, fkey: '0, fval: '0, ncur: '0};
    case (cmd)
      CMD_SET_OR_ADD, CMD_GET_OR_ADD: begin
        hit = probe_table(key, slot, reuse);
        if (hit == 1) begin
          if (cmd == CMD_SET_OR_ADD) shadow_value[slot] = val;
          r.sts = STS_HIT;
          r.fval = shadow_value[slot];
        end else if (hit == 0 && (reuse || populated < fill_limit)) begin
          if (!reuse) begin
            if (order_tail != 0) shadow_link[order_tail - 1] = CUR_W'(slot + 1);
            else order_head = CUR_W'(slot + 1);
            order_tail = CUR_W'(slot + 1);
            shadow_link[slot] = '0;
            populated++;
          end else begin
            reuse_seen++;
          end
          shadow_state[slot] = SLOT_LIVE;
          shadow_key[slot] = key;
          shadow_value[slot] = val;
          r.sts = STS_ADDED;
          r.fval = val;
        end else begin
          r.sts = STS_FULL;
          full_seen++;
        end
      end
      CMD_LOOKUP, CMD_LOOKUP_DEL: begin
        if (probe_table(key, slot, reuse) == 1) begin
          r.sts = STS_HIT;
          r.fval = shadow_value[slot];
          if (cmd == CMD_LOOKUP_DEL) begin
            shadow_state[slot] = SLOT_DELETED;
            shadow_key[slot] = '0;
            shadow_value[slot] = '0;
          end
        end
      end
      CMD_ITER_NEXT: begin
        // Deleted slots are skipped by following their stored link.
        r.ncur = CURSOR_END;
        pos = (cur == 0) ? int'(order_head) : int'(cur);
        for (int n = 0; n < CAPACITY; n++) begin
          if (pos == 0 || pos > CAPACITY) break;
          if (shadow_state[pos - 1] == SLOT_EMPTY) break;
          if (shadow_state[pos - 1] == SLOT_LIVE) begin
            r.sts = STS_HIT;
            r.fkey = shadow_key[pos - 1];
            r.fval = shadow_value[pos - 1];
            r.ncur = (shadow_link[pos - 1] != 0) ? shadow_link[pos - 1] : CURSOR_END;
            iter_hits++;
            break;
          end
          pos = int'(shadow_link[pos - 1]);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one transaction, possibly after an idle burst, and records its
  // expected result once the block has taken it.
  task automatic offer_item(input logic [2:0] cmd, input logic [KEY_W-1:0] key,
                            input logic [VAL_W-1:0] val, input logic [CUR_W-1:0] cur,
                            input bit typed, input map_result_t typed_res);
    map_result_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    lookup_key <= key;
    new_value  <= val;
    cursor     <= cur;
    do @(posedge clk); while (in_stall);
    predicted = apply_map_op(cmd, key, val, cur);
    if (cmd == CMD_ITER_NEXT) walk_cursor = predicted.ncur;
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // Register writes happen only with the block drained.
  task automatic write_limit(input logic [7:0] limit);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fill_limit = limit;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 47)];
    return {$urandom, $urandom};
  endfunction

  task automatic random_items(input int count);
    int w;
    logic [2:0] cmd;
    logic [CUR_W-1:0] cur;
    for (int i = 0; i < count; i++) begin
      w = $urandom_range(0, 99);
      if (w < 25) cmd = CMD_SET_OR_ADD;
      else if (w < 44) cmd = CMD_GET_OR_ADD;
      else if (w < 62) cmd = CMD_LOOKUP;
      else if (w < 78) cmd = CMD_LOOKUP_DEL;
      else if (w < 98) cmd = CMD_ITER_NEXT;
      else cmd = 3'($urandom_range(5, 7));
      // Iteration mostly walks the chain from the last cursor returned.
      w = $urandom_range(0, 9);
      if (w < 7) cur = (walk_cursor == CURSOR_END) ? '0 : walk_cursor;
      else if (w < 8) cur = '0;
      else cur = CUR_W'($urandom);
      offer_item(cmd, pick_key(), {$urandom, $urandom}, cur, 1'b0, '0);
    end
  endtask

  directed_row_t directed[$];

  function automatic directed_row_t mk_row(input logic [2:0] cmd, input logic [63:0] key,
      input logic [63:0] val, input logic [CUR_W-1:0] cur, input bit typed,
      input logic [1:0] sts, input logic [63:0] fkey, input logic [63:0] fval,
      input logic [CUR_W-1:0] ncur);
    directed_row_t d;
    d.cmd = cmd; d.key = key; d.val = val; d.cur = cur; d.typed = typed;
    d.res = '{sts: sts, fkey: fkey, fval: fval, ncur: ncur};
    return d;
  endfunction

  // Stimulus.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = '0;
    lookup_key = '0;
    new_value = '0;
    cursor = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    walk_cursor = '0;
    for (int s = 0; s < CAPACITY; s++) begin
      shadow_state[s] = SLOT_EMPTY;
      shadow_key[s] = '0;
      shadow_value[s] = '0;
      shadow_link[s] = '0;
    end
    order_head = '0;
    order_tail = '0;
    populated = 0;
    fill_limit = 8'd128;
    // Pool keys crowd a few home slots so that probes collide and wrap.
    for (int k = 0; k < 48; k++)
      key_pool[k] = {$urandom, $urandom_range(0, 1) ? $urandom :
                     32'($urandom_range(0, 15)) | (k < 8 ? 32'hF0 : 32'h0)};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table, unused codes, cursor extremes, all-ones key and value,
    // collisions on home slot zero, deletion, slot reuse and iteration.
    directed.push_back(mk_row(CMD_LOOKUP, 0, 0, 0, 1, STS_MISS, 0, 0, 0));
    directed.push_back(mk_row(CMD_ITER_NEXT, 0, 0, 0, 1, STS_MISS, 0, 0, CURSOR_END));
    directed.push_back(mk_row(CMD_ITER_NEXT, 0, 0, 9'h1FF, 1, STS_MISS, 0, 0, CURSOR_END));
    directed.push_back(mk_row(CMD_UNUSED_5, ALL_ONES, ALL_ONES, 9'h1FF, 1, STS_MISS, 0, 0, 0));
    directed.push_back(mk_row(CMD_UNUSED_6, 1, 1, 1, 1, STS_MISS, 0, 0, 0));
    directed.push_back(mk_row(CMD_UNUSED_7, 2, 2, 2, 1, STS_MISS, 0, 0, 0));
    directed.push_back(mk_row(CMD_SET_OR_ADD, ALL_ONES, ALL_ONES, 0, 1,
                              STS_ADDED, 0, ALL_ONES, 0));
    directed.push_back(mk_row(CMD_GET_OR_ADD, ALL_ONES, 5, 0, 1, STS_HIT, 0, ALL_ONES, 0));
    directed.push_back(mk_row(CMD_SET_OR_ADD, 0, 64'h11, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_SET_OR_ADD, 64'h100, 64'h22, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_GET_OR_ADD, 64'h200, 64'h33, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_SET_OR_ADD, 64'h100, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_LOOKUP, 64'h200, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_LOOKUP_DEL, 64'h100, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_LOOKUP_DEL, 64'h100, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_LOOKUP, 64'h200, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_ITER_NEXT, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_ITER_NEXT, 0, 0, 9'd1, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_ITER_NEXT, 0, 0, 9'd2, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_GET_OR_ADD, 64'h300, 64'h44, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_ITER_NEXT, 0, 0, 9'd3, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(CMD_ITER_NEXT, 0, 0, CURSOR_END, 1, STS_MISS, 0, 0, CURSOR_END));
    directed.push_back(mk_row(CMD_ITER_NEXT, 0, 0, 9'd200, 1, STS_MISS, 0, 0, CURSOR_END));
    foreach (directed[i])
      offer_item(directed[i].cmd, directed[i].key, directed[i].val, directed[i].cur,
                 directed[i].typed, directed[i].res);

    // Smallest limit: fresh inserts are refused, reuse still works.
    write_limit(8'd1);
    random_items(200);
    // Largest limit: fresh inserts may fill all but one slot.
    write_limit(8'd255);
    random_items(650);
    write_limit(8'($urandom_range(1, 255)));
    random_items(250);
    write_limit(8'd128);
    quiet = 1'b1;
    random_items(280);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d transactions: %0d full refusals, %0d deleted-slot reuses,",
             items_sent, full_seen, reuse_seen);
    $display("%0d entries returned by iteration, final populated count %0d.",
             iter_hits, populated);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: random stall bursts, one long hold-off so that the block
  // backs up into its input, and a check of every transaction taken.
  initial begin
    map_result_t want;
    int hold;
    out_stall = 1'b0;
    fail_count = 0;
    results_seen = 0;
    hold_done = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.sts) begin
            $error("status: expected %0d, got %0d", want.sts, status);
            fail_count++;
          end
          if (found_key !== want.fkey) begin
            $error("found_key: expected %h, got %h", want.fkey, found_key);
            fail_count++;
          end
          if (found_value !== want.fval) begin
            $error("found_value: expected %h, got %h", want.fval, found_value);
            fail_count++;
          end
          if (next_cursor !== want.ncur) begin
            $error("next_cursor: expected %0d, got %0d", want.ncur, next_cursor);
            fail_count++;
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_stall <= (hold != 0);
      end else if (!hold_done && results_seen == 300) begin
        hold_done = 1'b1;
        hold = 120;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #40ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
